FILE: rtl/pce_pkg.sv
`timescale 1ns / 1ps

package pce_pkg;

	localparam int CRC_W = 32;
	localparam int CRC_MIN_W = 8;
	localparam int BYTE_W = 8;
	localparam int CW_W = 6;
	localparam int SH_W = 5;
	localparam int IDX_W = 3;
	localparam int Q_AW = 2;
	localparam int Q_DEPTH = 1 << Q_AW;
	localparam int Q_CW = Q_AW + 1;

	localparam logic [CRC_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

	localparam logic [CW_W-1:0]  RST_WIDTH = 6'd32;
	localparam logic [CRC_W-1:0] RST_POLY = 32'h04C1_1DB7;
	localparam logic [CRC_W-1:0] RST_OXOR = 32'hFFFF_FFFF;

	typedef enum logic [IDX_W-1:0] {
		REG_CRC_WIDTH      = 3'd0,
		REG_POLYNOMIAL     = 3'd1,
		REG_REFLECT_INPUT  = 3'd2,
		REG_REFLECT_OUTPUT = 3'd3,
		REG_INIT_ALL_ONES  = 3'd4,
		REG_OUTPUT_XOR     = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [CW_W-1:0]  crc_width;
		logic [CRC_W-1:0] polynomial;
		logic             reflect_input;
		logic             reflect_output;
		logic             init_all_ones;
		logic [CRC_W-1:0] output_xor;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              start;
	} qent_t;

	typedef struct packed {
		logic            empty;
		logic            full;
		logic [Q_CW-1:0] count;
	} qstat_t;

	function automatic logic [BYTE_W-1:0] rev8(input logic [BYTE_W-1:0] v);
		logic [BYTE_W-1:0] r;
		for (int i = 0; i < BYTE_W; i++) begin
			r[i] = v[BYTE_W-1-i];
		end
		return r;
	endfunction

	function automatic logic [CRC_W-1:0] rev32(input logic [CRC_W-1:0] v);
		logic [CRC_W-1:0] r;
		for (int i = 0; i < CRC_W; i++) begin
			r[i] = v[CRC_W-1-i];
		end
		return r;
	endfunction

endpackage

FILE: rtl/pce_front.sv
`timescale 1ns / 1ps

module pce_front (
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [pce_pkg::BYTE_W-1:0] data_byte,
	input  logic                       start_of_message,
	input  logic                       reflect_input,
	input  pce_pkg::qstat_t            qstat,
	output logic                       push,
	output pce_pkg::qent_t             push_ent
);
	import pce_pkg::*;

	// take a byte whenever the queue has room
	assign in_stall = qstat.full;
	assign push = in_valid && !qstat.full;

	// byte is bit-reversed here when reflect_input is set, so the back end always works msb-first
	always_comb begin
		push_ent.data = reflect_input ? rev8(data_byte) : data_byte;
		push_ent.start = start_of_message;
	end

endmodule

FILE: rtl/pce_queue.sv
`timescale 1ns / 1ps

module pce_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pce_pkg::qent_t  push_ent,
	input  logic            pop,
	output pce_pkg::qent_t  pop_ent,
	output pce_pkg::qstat_t qstat
);
	import pce_pkg::*;

	qent_t           mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_CW-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_ent;
		end
	end

	assign pop_ent = mem_q[rd_ptr_q];

	always_comb begin
		qstat.count = count_q;
		qstat.empty = (count_q == '0);
		qstat.full = (count_q == Q_CW'(Q_DEPTH));
	end

endmodule

FILE: rtl/pce_back.sv
`timescale 1ns / 1ps

module pce_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pce_pkg::cfg_t             cfg,
	input  pce_pkg::qstat_t           qstat,
	input  pce_pkg::qent_t            pop_ent,
	output logic                      pop,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [pce_pkg::CRC_W-1:0] crc_value
);
	import pce_pkg::*;

	logic [CRC_W-1:0] rem_q;
	logic [CRC_W-1:0] crc_q;
	logic             out_valid_q;

	logic [CW_W-1:0]  eff_w;
	logic [SH_W-1:0]  sh;
	logic [CRC_W-1:0] mask;
	logic [CRC_W-1:0] rem_al;
	logic [CRC_W-1:0] poly_al;
	logic [CRC_W-1:0] acc;
	logic [CRC_W-1:0] rem_nxt;
	logic [CRC_W-1:0] crc_nxt;

	// width clamped into 8..32; the remainder is stored right-aligned and left-aligned in 32 bits for the update
	always_comb begin
		if (cfg.crc_width < CW_W'(CRC_MIN_W)) begin
			eff_w = CW_W'(CRC_MIN_W);
		end else if (cfg.crc_width > CW_W'(CRC_W)) begin
			eff_w = CW_W'(CRC_W);
		end else begin
			eff_w = cfg.crc_width;
		end
		sh = SH_W'(CW_W'(CRC_W) - eff_w);
		mask = ALL_ONES >> sh;
	end

	always_comb begin
		if (pop_ent.start) begin
			rem_al = cfg.init_all_ones ? (ALL_ONES << sh) : '0;
		end else begin
			rem_al = rem_q << sh;
		end
		poly_al = cfg.polynomial << sh;
		acc = rem_al ^ {pop_ent.data, {(CRC_W-BYTE_W){1'b0}}};
		for (int i = 0; i < BYTE_W; i++) begin
			if (acc[CRC_W-1]) begin
				acc = (acc << 1) ^ poly_al;
			end else begin
				acc = acc << 1;
			end
		end
		rem_nxt = acc >> sh;
		// full reversal of the aligned word equals reversal over the width
		crc_nxt = ((cfg.reflect_output ? rev32(acc) : rem_nxt) ^ cfg.output_xor) & mask;
	end

	assign pop = !qstat.empty && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				rem_q <= rem_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			crc_q <= crc_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign crc_value = crc_q;

endmodule

FILE: rtl/parameterized_crc_engine.sv
`timescale 1ns / 1ps
// channel   signals                                   transaction when
// in        in_valid in_stall data_byte start_of_msg  in_valid && !in_stall
// out       out_valid out_stall crc_value             out_valid && !out_stall
// cfg       cfg_valid cfg_ready cfg_index cfg_data    cfg_valid && cfg_ready
//
// one byte per cycle sustained while out_stall is low; a byte's crc reaches the output after its
// transaction by way of the queue write, then the eight-step shift-xor into the output register
// a four-entry queue sits between front and back; in_stall rises only when it is full
// the back end keeps draining while out_stall is low, so both sides stall independently
// reset clears the remainder to zero and loads the default crc-32 settings

module parameterized_crc_engine (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [pce_pkg::BYTE_W-1:0]   data_byte,
	input  logic                         start_of_message,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [pce_pkg::CRC_W-1:0]    crc_value,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [pce_pkg::IDX_W-1:0]    cfg_index,
	input  logic [pce_pkg::CRC_W-1:0]    cfg_data
);
	import pce_pkg::*;

	cfg_t   cfg_q;
	qstat_t qstat;
	qent_t  push_ent;
	qent_t  pop_ent;
	logic   push;
	logic   pop;

	// config writes are always accepted
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.crc_width <= RST_WIDTH;
			cfg_q.polynomial <= RST_POLY;
			cfg_q.reflect_input <= 1'b1;
			cfg_q.reflect_output <= 1'b1;
			cfg_q.init_all_ones <= 1'b1;
			cfg_q.output_xor <= RST_OXOR;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CRC_WIDTH: cfg_q.crc_width <= cfg_data[CW_W-1:0];
				REG_POLYNOMIAL: cfg_q.polynomial <= cfg_data;
				REG_REFLECT_INPUT: cfg_q.reflect_input <= cfg_data[0];
				REG_REFLECT_OUTPUT: cfg_q.reflect_output <= cfg_data[0];
				REG_INIT_ALL_ONES: cfg_q.init_all_ones <= cfg_data[0];
				REG_OUTPUT_XOR: cfg_q.output_xor <= cfg_data;
				default: ; // unmapped index, write dropped
			endcase
		end
	end

	// front: takes bytes, applies input reflection, fills the queue
	pce_front u_front (
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.data_byte        (data_byte),
		.start_of_message (start_of_message),
		.reflect_input    (cfg_q.reflect_input),
		.qstat            (qstat),
		.push             (push),
		.push_ent         (push_ent)
	);

	pce_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ent (push_ent),
		.pop      (pop),
		.pop_ent  (pop_ent),
		.qstat    (qstat)
	);

	// back: remainder update and finished crc into the output register
	pce_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.qstat     (qstat),
		.pop_ent   (pop_ent),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.crc_value (crc_value)
	);

	// queue occupancy never passes its depth
	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.count <= Q_CW'(Q_DEPTH))
		else $error("queue count beyond depth");

	// the back end never reads an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty queue");

	// an accepted byte leaves the queue non-empty on the next cycle
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> !qstat.empty)
		else $error("accepted byte lost");

	// input stall only when the queue is full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (qstat.count == Q_CW'(Q_DEPTH)))
		else $error("input stalled with queue room");

endmodule
